/* design/assert_macros.svh */
// Assertion macros used by the tracker design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

/* design/lbpt_pkg.sv */
`default_nettype none
package lbpt_pkg;
    localparam int MAX_FRAMES_DEF = 16;
    localparam int OFS_W          = 31;
    localparam int CNT_W          = 32;
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE   = 1'd1;

    localparam logic [CFG_W-1:0] FSL_RESET = 5'd12;
    localparam logic [CFG_W-1:0] FIU_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_UPD
    } t_state;

    typedef struct packed {
        logic             mode;
        logic [OFS_W-1:0] offset;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic [3:0]       found_position;
        logic [OFS_W-1:0] block_base;
        logic             evicted;
        logic             evicted_dirty;
        logic [OFS_W-1:0] evicted_base;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] writeback_count;
    } t_out_item;
endpackage
`default_nettype wire

/* design/lru_buffer_pool_tracker.sv */
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_ready      lbpt_pkg::t_in_item
// result    out        o_valid / i_ready      lbpt_pkg::t_out_item
// config    in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
// Each accepted access is scanned with a read and a compare step per resident position
// until a hit or the list end, then updated; no new access is taken until then.
// The scan reads the frame base memory one position at a time through its single read port.
// Reset is synchronous and active low; it empties the pool and clears the counters.
// A result beat waits in the output register; the next access is taken meanwhile but
// holds in its update step until that beat has gone.
`default_nettype none
`include "assert_macros.svh"
module lru_buffer_pool_tracker #(
    parameter int MAX_FRAMES = lbpt_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lbpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lbpt_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire lbpt_pkg::t_in_item              i_in,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output lbpt_pkg::t_out_item                  o_out
);
    localparam int PW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int LW = (CW > lbpt_pkg::CFG_W) ? CW : lbpt_pkg::CFG_W;
    localparam int OW = lbpt_pkg::OFS_W;
    localparam int NW = lbpt_pkg::CNT_W;

    lbpt_pkg::t_state   r_state, n_state;
    logic [4:0]         r_fsl;
    logic [4:0]         r_fiu;
    logic [PW-1:0]      r_order [MAX_FRAMES];
    logic [PW-1:0]      n_order [MAX_FRAMES];
    logic               r_dirty [MAX_FRAMES];
    logic               n_dirty [MAX_FRAMES];
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;
    logic [PW-1:0]      r_slot, n_slot;
    logic [PW-1:0]      r_pos, n_pos;
    logic               r_hit, n_hit;
    logic               r_wr, n_wr;
    logic [OW-1:0]      r_base, n_base;
    logic [OW-1:0]      r_evb, n_evb;
    logic [NW-1:0]      r_hits, n_hits;
    logic [NW-1:0]      r_miss, n_miss;
    logic [NW-1:0]      r_wbs, n_wbs;
    logic               r_out_valid, n_out_valid;
    lbpt_pkg::t_out_item r_out, n_out;

    logic [LW-1:0]      lim;
    logic               full;
    logic               evict;
    logic               do_shift;
    logic [PW-1:0]      slot;
    logic [CW-1:0]      last;
    logic               ram_we;
    logic               ram_re;
    logic [PW-1:0]      ram_raddr;
    logic [OW-1:0]      ram_rdata;

    lbpt_ram #(
        .WIDTH(OW),
        .DEPTH(MAX_FRAMES)
    ) u_bases (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(slot),
        .i_wdata(r_base),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        lim = LW'(r_fiu);
        if (lim == '0) begin
            lim = LW'(1);
        end
        if (lim > LW'(MAX_FRAMES)) begin
            lim = LW'(MAX_FRAMES);
        end
        full     = LW'(r_count) >= lim;
        evict    = !r_hit && full;
        do_shift = r_hit || evict;
        slot     = evict ? r_order[0] : r_slot;
        last     = r_count - CW'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_order     = r_order;
        n_dirty     = r_dirty;
        n_count     = r_count;
        n_k         = r_k;
        n_slot      = r_slot;
        n_pos       = r_pos;
        n_hit       = r_hit;
        n_wr        = r_wr;
        n_base      = r_base;
        n_evb       = r_evb;
        n_hits      = r_hits;
        n_miss      = r_miss;
        n_wbs       = r_wbs;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_ready     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_order[r_k[PW-1:0]];
        unique case (r_state)
            lbpt_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_wr    = i_in.mode;
                    n_base  = i_in.offset & (OW'({OW{1'b1}}) << r_fsl);
                    n_k     = '0;
                    n_state = lbpt_pkg::S_RD;
                end
            end
            lbpt_pkg::S_RD: begin
                n_slot = r_order[r_k[PW-1:0]];
                if (r_k == r_count) begin
                    n_hit   = 1'b0;
                    n_pos   = '0;
                    n_state = lbpt_pkg::S_UPD;
                end else begin
                    ram_re  = 1'b1;
                    n_state = lbpt_pkg::S_CMP;
                end
            end
            lbpt_pkg::S_CMP: begin
                if (r_k == '0) begin
                    n_evb = ram_rdata;
                end
                if (ram_rdata == r_base) begin
                    n_hit   = 1'b1;
                    n_pos   = r_k[PW-1:0];
                    n_state = lbpt_pkg::S_UPD;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = lbpt_pkg::S_RD;
                end
            end
            lbpt_pkg::S_UPD: begin
                if (!r_out_valid || i_ready) begin
                    n_state     = lbpt_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    ram_we      = !r_hit;
                    for (int i = 0; i < MAX_FRAMES; i++) begin
                        if (do_shift) begin
                            if (CW'(i) == last) begin
                                n_order[i] = slot;
                            end else if (CW'(i) >= CW'(r_pos) && CW'(i) < last) begin
                                n_order[i] = r_order[(i + 1) % MAX_FRAMES];
                            end
                        end
                    end
                    n_dirty[slot] = r_hit ? (r_dirty[slot] | r_wr) : r_wr;
                    if (!r_hit && !full) begin
                        n_count = r_count + CW'(1);
                    end
                    if (r_hit) begin
                        n_hits = (&r_hits) ? r_hits : r_hits + NW'(1);
                    end else begin
                        n_miss = (&r_miss) ? r_miss : r_miss + NW'(1);
                    end
                    if (evict && r_dirty[r_order[0]]) begin
                        n_wbs = (&r_wbs) ? r_wbs : r_wbs + NW'(1);
                    end
                    n_out.hit             = r_hit;
                    n_out.found_position  = r_hit ? 4'(r_pos) : 4'd0;
                    n_out.block_base      = r_base;
                    n_out.evicted         = evict;
                    n_out.evicted_dirty   = evict && r_dirty[r_order[0]];
                    n_out.evicted_base    = evict ? r_evb : '0;
                    n_out.hit_count       = n_hits;
                    n_out.miss_count      = n_miss;
                    n_out.writeback_count = n_wbs;
                end
            end
            default: begin
                n_state = lbpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbpt_pkg::S_IDLE;
            r_fsl       <= lbpt_pkg::FSL_RESET;
            r_fiu       <= lbpt_pkg::FIU_RESET;
            r_count     <= '0;
            r_hits      <= '0;
            r_miss      <= '0;
            r_wbs       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_order[i] <= PW'(i);
                r_dirty[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hits      <= n_hits;
            r_miss      <= n_miss;
            r_wbs       <= n_wbs;
            r_out_valid <= n_out_valid;
            r_order     <= n_order;
            r_dirty     <= n_dirty;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lbpt_pkg::CFG_FRAME_SIZE_LOG2: r_fsl <= i_cfg_data;
                    lbpt_pkg::CFG_FRAMES_IN_USE:   r_fiu <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_slot <= n_slot;
        r_pos  <= n_pos;
        r_hit  <= n_hit;
        r_wr   <= n_wr;
        r_base <= n_base;
        r_evb  <= n_evb;
        r_out  <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    `ASSERT_RST(a_count_max, i_clk, i_rst_n, r_count <= CW'(MAX_FRAMES),
        "occupancy above pool size")
    `ASSERT_RST(a_cmp_after_rd, i_clk, i_rst_n,
        (r_state == lbpt_pkg::S_CMP) |-> ($past(r_state) == lbpt_pkg::S_RD),
        "compare without read")
    `ASSERT_RST(a_accept_scan, i_clk, i_rst_n,
        (i_valid && o_ready) |=> (r_state == lbpt_pkg::S_RD),
        "accepted access did not start scan")
    `ASSERT_RST(a_out_from_upd, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == lbpt_pkg::S_UPD),
        "result beat not from update")
endmodule
`default_nettype wire

/* design/lbpt_ram.sv */
`default_nettype none
module lbpt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int NFR = lbpt_pkg::MAX_FRAMES_DEF;
    localparam int OW  = lbpt_pkg::OFS_W;
    localparam int NW  = lbpt_pkg::CNT_W;
    localparam int CFW = lbpt_pkg::CFG_W;
    localparam int IW  = lbpt_pkg::CFG_IDX_W;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IW-1:0] i_cfg_idx = '0;
    logic [CFW-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    lbpt_pkg::t_in_item i_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    lbpt_pkg::t_out_item o_out;

    lru_buffer_pool_tracker u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out)
    );

    // Shadow copy of the directory.
    logic [4:0] shift_log2;
    logic [4:0] pool_size;
    logic [OW-1:0] res_base [NFR];
    logic res_dirty [NFR];
    int resident;
    logic [NW-1:0] n_hits, n_misses, n_wbacks;

    lbpt_pkg::t_in_item access_q[$];
    lbpt_pkg::t_out_item lookup_q[$];
    int fails = 0;
    int hold_off = 0;
    logic hold_req = 1'b0;

    function automatic logic [NW-1:0] sat_add(logic [NW-1:0] v);
        return (v == '1) ? v : v + NW'(1);
    endfunction

    task automatic predict_lookup(lbpt_pkg::t_in_item a);
        lbpt_pkg::t_out_item r;
        logic [OW-1:0] base;
        int lim;
        int p;
        logic d;
        r = '0;
        base = OW'(32'(a.offset) & ~((32'h1 << shift_log2) - 32'h1));
        p = -1;
        for (int i = 0; i < resident; i++) begin
            if (p < 0 && res_base[i] == base) p = i;
        end
        r.block_base = base;
        if (p >= 0) begin
            r.hit = 1'b1;
            r.found_position = p[3:0];
            d = res_dirty[p] | a.mode;
            for (int i = p; i + 1 < resident; i++) begin
                res_base[i] = res_base[i+1];
                res_dirty[i] = res_dirty[i+1];
            end
            res_base[resident-1] = base;
            res_dirty[resident-1] = d;
            n_hits = sat_add(n_hits);
        end else begin
            lim = (pool_size == 0) ? 1 : (int'(pool_size) > NFR ? NFR : int'(pool_size));
            if (resident >= lim) begin
                r.evicted = 1'b1;
                r.evicted_dirty = res_dirty[0];
                r.evicted_base = res_base[0];
                if (res_dirty[0]) n_wbacks = sat_add(n_wbacks);
                for (int i = 0; i + 1 < resident; i++) begin
                    res_base[i] = res_base[i+1];
                    res_dirty[i] = res_dirty[i+1];
                end
                resident--;
            end
            res_base[resident] = base;
            res_dirty[resident] = a.mode;
            resident++;
            n_misses = sat_add(n_misses);
        end
        r.hit_count = n_hits;
        r.miss_count = n_misses;
        r.writeback_count = n_wbacks;
        lookup_q.push_back(r);
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Beat accepted at the previous rising edge.
    logic o_ready_q = 1'b0;
    always @(posedge i_clk) begin
        o_ready_q <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) predict_lookup(i_in);
    end

    // Driver: offers accesses from the queue with random gaps, or back to back while no_gaps is set.
    int send_gap = 0;
    logic no_gaps = 1'b0;
    always @(negedge i_clk) begin
        if (i_valid && o_ready_q) begin
            if (access_q.size() > 0 && (send_gap == 0 || no_gaps)) begin
                i_in <= access_q.pop_front();
                send_gap <= no_gaps ? 0 : gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (send_gap > 0 && !no_gaps) begin
                send_gap <= send_gap - 1;
            end else if (access_q.size() > 0) begin
                i_in <= access_q.pop_front();
                i_valid <= 1'b1;
                send_gap <= no_gaps ? 0 : gap_len();
            end
        end
    end

    // Receiver stall pattern.
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (hold_req) begin
            i_ready <= 1'b0;
            hold_off <= hold_off + 1;
        end else if (recv_gap > 0) begin
            i_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            i_ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) recv_gap <= gap_len();
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        lbpt_pkg::t_out_item e;
        if (i_rst_n && o_valid && i_ready) begin
            if (lookup_q.size() == 0) begin
                $error("result beat with nothing expected");
                fails++;
            end else begin
                e = lookup_q.pop_front();
                if (o_out.hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, o_out.hit); fails++;
                end
                if (o_out.found_position !== e.found_position) begin
                    $error("found_position exp %0d got %0d", e.found_position,
                           o_out.found_position);
                    fails++;
                end
                if (o_out.block_base !== e.block_base) begin
                    $error("block_base exp %h got %h", e.block_base, o_out.block_base);
                    fails++;
                end
                if (o_out.evicted !== e.evicted) begin
                    $error("evicted exp %0d got %0d", e.evicted, o_out.evicted); fails++;
                end
                if (o_out.evicted_dirty !== e.evicted_dirty) begin
                    $error("evicted_dirty exp %0d got %0d", e.evicted_dirty,
                           o_out.evicted_dirty);
                    fails++;
                end
                if (o_out.evicted_base !== e.evicted_base) begin
                    $error("evicted_base exp %h got %h", e.evicted_base, o_out.evicted_base);
                    fails++;
                end
                if (o_out.hit_count !== e.hit_count) begin
                    $error("hit_count exp %0d got %0d", e.hit_count, o_out.hit_count);
                    fails++;
                end
                if (o_out.miss_count !== e.miss_count) begin
                    $error("miss_count exp %0d got %0d", e.miss_count, o_out.miss_count);
                    fails++;
                end
                if (o_out.writeback_count !== e.writeback_count) begin
                    $error("writeback_count exp %0d got %0d", e.writeback_count,
                           o_out.writeback_count);
                    fails++;
                end
            end
        end
    end

    task automatic add_access(logic m, logic [OW-1:0] ofs);
        lbpt_pkg::t_in_item a;
        a.mode = m;
        a.offset = ofs;
        access_q.push_back(a);
    endtask

    task automatic wait_drained();
        while (access_q.size() > 0 || i_valid || lookup_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [IW-1:0] idx, logic [CFW-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lbpt_pkg::CFG_FRAME_SIZE_LOG2) shift_log2 = v;
        else pool_size = v;
    endtask

    // Random phase: mostly offsets drawn from a small working set to make hits.
    task automatic random_phase(int count);
        logic [OW-1:0] ws [24];
        logic [OW-1:0] o;
        int nws;
        nws = $urandom_range(2, 24);
        for (int i = 0; i < nws; i++) ws[i] = OW'($urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 8)
                o = ws[$urandom_range(0, nws - 1)]
                    ^ OW'($urandom & ((32'h1 << shift_log2) - 32'h1));
            else
                o = OW'($urandom);
            add_access(1'($urandom_range(0, 1)), o);
        end
    endtask

    initial begin
        shift_log2 = lbpt_pkg::FSL_RESET;
        pool_size = lbpt_pkg::FIU_RESET;
        resident = 0;
        n_hits = '0;
        n_misses = '0;
        n_wbacks = '0;
        for (int i = 0; i < NFR; i++) begin
            res_base[i] = '0;
            res_dirty[i] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, read and write, hits at the oldest position, eviction.
        add_access(1'b0, 31'h0);
        add_access(1'b1, 31'h7FFF_FFFF);
        add_access(1'b0, 31'h0000_0FFF);
        add_access(1'b1, 31'h7FFF_F000);
        add_access(1'b0, 31'h5555_5555);
        add_access(1'b1, 31'h2AAA_AAAA);
        wait_drained();
        set_reg(lbpt_pkg::CFG_FRAMES_IN_USE, 5'd2);
        add_access(1'b1, 31'h1000);
        add_access(1'b0, 31'h2000);
        add_access(1'b0, 31'h1000);
        add_access(1'b0, 31'h3000);
        add_access(1'b0, 31'h4000);
        wait_drained();
        set_reg(lbpt_pkg::CFG_FRAMES_IN_USE, 5'd0);
        set_reg(lbpt_pkg::CFG_FRAME_SIZE_LOG2, 5'd31);
        add_access(1'b1, 31'h1234_5678);
        add_access(1'b0, 31'h7654_3210);
        wait_drained();
        set_reg(lbpt_pkg::CFG_FRAMES_IN_USE, 5'd31);
        set_reg(lbpt_pkg::CFG_FRAME_SIZE_LOG2, 5'd0);
        add_access(1'b0, 31'h1);
        add_access(1'b1, 31'h2);
        wait_drained();

        // Back-pressure: receiver holds off while the sender keeps offering.
        no_gaps = 1'b1;
        set_reg(lbpt_pkg::CFG_FRAME_SIZE_LOG2, 5'd4);
        hold_req = 1'b1;
        random_phase(40);
        while (hold_off < 300) @(posedge i_clk);
        hold_req = 1'b0;
        wait_drained();
        no_gaps = 1'b0;

        for (int ph = 0; ph < 9; ph++) begin
            set_reg(lbpt_pkg::CFG_FRAME_SIZE_LOG2,
                    CFW'((ph == 0) ? 16 : (ph == 1) ? 0 : $urandom_range(0, 16)));
            set_reg(lbpt_pkg::CFG_FRAMES_IN_USE,
                    CFW'((ph == 2) ? 1 : (ph == 3) ? 16 : $urandom_range(1, 16)));
            random_phase(140);
            wait_drained();
        end

        if (fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/lbpt_pkg.sv
design/lbpt_ram.sv
design/lru_buffer_pool_tracker.sv
dv/tb.sv
